### rtl/core/bgrs_pkg.sv
// Shared types and constants of the bounded grid reach search block.
// Holds payload structs, request and register codes, and the control bundles.
// No dependencies.
package bgrs_pkg;

	// Default sizes handed to the top level parameters.
	localparam int DEF_MAX_COLS   = 64;
	localparam int DEF_MAX_ROWS   = 64;
	localparam int DEF_LEVEL_BITS = 8;

	// Field widths fixed by the port contract.
	localparam int COORD_W    = 6;
	localparam int LEVEL_IN_W = 8;
	localparam int STEPS_W    = 6;
	localparam int COUNT_W    = 13;
	localparam int DIST_W     = 7;
	localparam int CFG_DIM_W  = 7;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 8;

	// Distance code of a tile that the last search did not reach.
	localparam logic [DIST_W-1:0] UNREACHED = 7'd127;

	// Request codes.
	localparam logic [1:0] REQ_WRITE  = 2'd0;
	localparam logic [1:0] REQ_SEARCH = 2'd1;
	localparam logic [1:0] REQ_QUERY  = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_JUMP_LIMIT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FALL_LIMIT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MOVE_RANGE  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_START_X     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_START_Y     = 3'd6;

	typedef struct packed {
		logic [1:0]            req_type;
		logic [COORD_W-1:0]    tile_x;
		logic [COORD_W-1:0]    tile_y;
		logic [LEVEL_IN_W-1:0] tile_level;
	} req_t;

	typedef struct packed {
		logic               status;
		logic               reachable;
		logic [STEPS_W-1:0] steps_used;
		logic [COUNT_W-1:0] reachable_count;
	} rsp_t;

	// Which response the datapath assembles.
	typedef enum logic [1:0] {
		RSP_WRITE,
		RSP_NONE,
		RSP_QUERY,
		RSP_SEARCH
	} rsp_sel_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic     sweep_lvl;
		logic     sweep_dst;
		logic     wr_level;
		logic     q_capture;
		logic     seed;
		logic     pop;
		logic     cur_load;
		logic     exp_load;
		logic     nb_issue;
		logic     nb_next;
		logic     nb_commit;
		logic     rsp_load;
		rsp_sel_t rsp_sel;
	} bgrs_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic sweep_last;
		logic start_in;
		logic queue_empty;
		logic cur_done;
		logic nb_valid;
		logic k_last;
		logic rsp_busy;
	} bgrs_sts_t;

endpackage

### rtl/core/bgrs_datapath.sv
// Datapath of the reach search: configuration registers, height, distance and
// visit queue memories, search pointers and the response register.
// Depends on bgrs_pkg.
module bgrs_datapath
	import bgrs_pkg::*;
#(
	parameter int MAX_COLS   = DEF_MAX_COLS,
	parameter int MAX_ROWS   = DEF_MAX_ROWS,
	parameter int LEVEL_BITS = DEF_LEVEL_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  req_t                  req,
	input  logic                  rsp_stall,
	output logic                  rsp_valid,
	output rsp_t                  rsp,
	input  bgrs_cmd_t             cmd,
	output bgrs_sts_t             sts
);

	localparam int XW    = $clog2(MAX_COLS);
	localparam int YW    = $clog2(MAX_ROWS);
	localparam int AW    = XW + YW;
	localparam int DEPTH = 1 << AW;
	localparam int MW    = ((XW > YW) ? XW : YW) + 1;
	localparam int CW    = (MW > CFG_DIM_W) ? MW : CFG_DIM_W;
	localparam int LW    = LEVEL_BITS;
	localparam int DW    = (LW > 8) ? LW : 8;

	typedef enum logic [1:0] {
		DIR_E,
		DIR_W,
		DIR_S,
		DIR_N
	} dir_t;

	// Configuration registers
	logic [CFG_DIM_W-1:0] grid_w_q, grid_h_q;
	logic [7:0]           jump_q, fall_q;
	logic [5:0]           range_q, sx_q, sy_q;

	// Search control
	logic [AW-1:0]      sweep_q;
	logic [AW:0]        head_q, tail_q;
	logic [COUNT_W-1:0] cnt_q, found_q;
	dir_t               k_q;
	logic               rsp_valid_q;

	// Payload registers
	logic [AW-1:0]      cur_addr_q, nb_addr_q;
	logic [STEPS_W-1:0] cur_d_q;
	logic [LW-1:0]      cur_lvl_q;
	logic               qok_q;
	rsp_t               rsp_q;

	// Memories and their registered read data
	logic [LW-1:0]     level_mem [DEPTH];
	logic [DIST_W-1:0] dist_mem  [DEPTH];
	logic [AW-1:0]     queue_mem [DEPTH];
	logic [LW-1:0]     lvl_rd_q;
	logic [DIST_W-1:0] dst_rd_q;
	logic [AW-1:0]     que_rd_q;

	logic [CW-1:0] eff_w, eff_h, req_xc, req_yc, sxc, syc, cxc, cyc, nx, ny;
	logic          req_in, start_in, under, nb_valid, take, step_ok;
	logic [AW-1:0] req_addr, start_addr, nb_addr, rd_addr;
	logic          lvl_we, dst_we, que_we;
	logic [AW-1:0] lvl_wa, dst_wa, que_wa;
	logic [LW-1:0] lvl_wd;
	logic [DIST_W-1:0] dst_wd;
	logic [AW-1:0] que_wd;
	rsp_t          rsp_d;

	// Effective grid size and bounds checks
	assign eff_w = (CW'(grid_w_q) > CW'(MAX_COLS)) ? CW'(MAX_COLS) : CW'(grid_w_q);
	assign eff_h = (CW'(grid_h_q) > CW'(MAX_ROWS)) ? CW'(MAX_ROWS) : CW'(grid_h_q);
	assign req_xc = CW'(req.tile_x);
	assign req_yc = CW'(req.tile_y);
	assign sxc    = CW'(sx_q);
	assign syc    = CW'(sy_q);
	assign req_in   = (req_xc < eff_w) && (req_yc < eff_h);
	assign start_in = (sxc < eff_w) && (syc < eff_h);
	assign req_addr   = {req_yc[YW-1:0], req_xc[XW-1:0]};
	assign start_addr = {syc[YW-1:0], sxc[XW-1:0]};

	// Neighbor of the current tile in direction k
	assign cxc = CW'(cur_addr_q[XW-1:0]);
	assign cyc = CW'(cur_addr_q[AW-1:XW]);
	always_comb begin
		nx    = cxc;
		ny    = cyc;
		under = 1'b0;
		unique case (k_q)
			DIR_E: nx = cxc + CW'(1);
			DIR_W: begin
				nx    = cxc - CW'(1);
				under = (cxc == '0);
			end
			DIR_S: ny = cyc + CW'(1);
			DIR_N: begin
				ny    = cyc - CW'(1);
				under = (cyc == '0);
			end
			default: ;
		endcase
	end
	assign nb_valid = !under && (nx < eff_w) && (ny < eff_h);
	assign nb_addr  = {ny[YW-1:0], nx[XW-1:0]};

	// Climb and drop limits
	always_comb begin
		if (lvl_rd_q > cur_lvl_q) begin
			step_ok = DW'(lvl_rd_q - cur_lvl_q) <= DW'(jump_q);
		end else begin
			step_ok = DW'(cur_lvl_q - lvl_rd_q) <= DW'(fall_q);
		end
	end
	assign take = (dst_rd_q == UNREACHED) && step_ok;

	// Status to the controller
	assign sts.sweep_last  = &sweep_q;
	assign sts.start_in    = start_in;
	assign sts.queue_empty = (head_q == tail_q);
	assign sts.cur_done    = dst_rd_q >= {1'b0, range_q};
	assign sts.nb_valid    = nb_valid;
	assign sts.k_last      = (k_q == DIR_N);
	assign sts.rsp_busy    = rsp_valid_q && rsp_stall;

	// Memory port selection
	always_comb begin
		lvl_we = cmd.sweep_lvl || (cmd.wr_level && req_in);
		lvl_wa = cmd.sweep_lvl ? sweep_q : req_addr;
		lvl_wd = cmd.sweep_lvl ? '0 : LW'(req.tile_level);

		dst_we = 1'b0;
		dst_wa = sweep_q;
		dst_wd = UNREACHED;
		if (cmd.sweep_lvl || cmd.sweep_dst) begin
			dst_we = 1'b1;
		end else if (cmd.seed) begin
			dst_we = start_in;
			dst_wa = start_addr;
			dst_wd = '0;
		end else if (cmd.nb_commit) begin
			dst_we = take;
			dst_wa = nb_addr_q;
			dst_wd = {1'b0, cur_d_q} + DIST_W'(1);
		end

		que_we = cmd.seed || (cmd.nb_commit && take);
		que_wa = cmd.seed ? '0 : tail_q[AW-1:0];
		que_wd = cmd.seed ? start_addr : nb_addr_q;

		if (cmd.cur_load) begin
			rd_addr = que_rd_q;
		end else if (cmd.nb_issue) begin
			rd_addr = nb_addr;
		end else begin
			rd_addr = req_addr;
		end
	end

	always_ff @(posedge clk) begin
		if (lvl_we) begin
			level_mem[lvl_wa] <= lvl_wd;
		end
		lvl_rd_q <= level_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (dst_we) begin
			dist_mem[dst_wa] <= dst_wd;
		end
		dst_rd_q <= dist_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (que_we) begin
			queue_mem[que_wa] <= que_wd;
		end
		que_rd_q <= queue_mem[head_q[AW-1:0]];
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_w_q <= 7'd64;
			grid_h_q <= 7'd64;
			jump_q   <= 8'd1;
			fall_q   <= 8'd2;
			range_q  <= 6'd4;
			sx_q     <= '0;
			sy_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_GRID_WIDTH:  grid_w_q <= cfg_data[CFG_DIM_W-1:0];
				CFG_GRID_HEIGHT: grid_h_q <= cfg_data[CFG_DIM_W-1:0];
				CFG_JUMP_LIMIT:  jump_q   <= cfg_data;
				CFG_FALL_LIMIT:  fall_q   <= cfg_data;
				CFG_MOVE_RANGE:  range_q  <= cfg_data[5:0];
				CFG_START_X:     sx_q     <= cfg_data[5:0];
				CFG_START_Y:     sy_q     <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// Search pointers and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
			head_q  <= '0;
			tail_q  <= '0;
			cnt_q   <= '0;
			found_q <= '0;
			k_q     <= DIR_E;
		end else begin
			if (cmd.sweep_lvl || cmd.sweep_dst) begin
				sweep_q <= sweep_q + AW'(1);
			end
			if (cmd.seed) begin
				head_q <= '0;
				tail_q <= (AW+1)'(1);
				cnt_q  <= start_in ? COUNT_W'(1) : '0;
			end
			if (cmd.pop) begin
				head_q <= head_q + (AW+1)'(1);
			end
			if (cmd.nb_commit && take) begin
				tail_q <= tail_q + (AW+1)'(1);
				cnt_q  <= cnt_q + COUNT_W'(1);
			end
			if (cmd.exp_load) begin
				k_q <= DIR_E;
			end else if (cmd.nb_next) begin
				k_q <= dir_t'(2'(k_q) + 2'd1);
			end
			if (cmd.rsp_load && cmd.rsp_sel == RSP_SEARCH) begin
				found_q <= cnt_q;
			end
		end
	end

	// Current tile and neighbor capture
	always_ff @(posedge clk) begin
		if (cmd.cur_load) begin
			cur_addr_q <= que_rd_q;
		end
		if (cmd.exp_load) begin
			cur_d_q   <= dst_rd_q[STEPS_W-1:0];
			cur_lvl_q <= lvl_rd_q;
		end
		if (cmd.nb_issue) begin
			nb_addr_q <= nb_addr;
		end
		if (cmd.q_capture) begin
			qok_q <= req_in;
		end
	end

	// Assemble the response
	always_comb begin
		rsp_d                 = '0;
		rsp_d.reachable_count = found_q;
		unique case (cmd.rsp_sel)
			RSP_WRITE: rsp_d.status = !req_in;
			RSP_NONE:  ;
			RSP_QUERY: begin
				rsp_d.status = !qok_q;
				if (qok_q && dst_rd_q != UNREACHED) begin
					rsp_d.reachable  = 1'b1;
					rsp_d.steps_used = dst_rd_q[STEPS_W-1:0];
				end
			end
			RSP_SEARCH: begin
				rsp_d.status          = !start_in;
				rsp_d.reachable_count = cnt_q;
			end
			default: ;
		endcase
	end

	// Output register: load a result, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	a_head_le_tail: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= tail_q)
		else $error("visit queue head passed tail");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rsp_load |-> !(rsp_valid_q && rsp_stall))
		else $error("result loaded over a stalled result");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> (head_q != tail_q))
		else $error("pop from empty visit queue");
`endif

endmodule

### rtl/core/bgrs_ctrl.sv
// Controller of the reach search: request decode and the search sequence.
// Drives datapath commands from datapath status. Depends on bgrs_pkg.
module bgrs_ctrl
	import bgrs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  logic [1:0] req_type,
	output logic      req_stall,
	input  bgrs_sts_t sts,
	output bgrs_cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_QRY,
		ST_CLR,
		ST_SEED,
		ST_POP,
		ST_CUR,
		ST_EXP,
		ST_NB,
		ST_CHK,
		ST_DONE
	} state_t;

	state_t state_q, state_d;
	logic   ready;

	assign ready     = (state_q == ST_IDLE) && !sts.rsp_busy;
	assign req_stall = !ready;

	// Commands and next state
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_INIT: begin
				cmd.sweep_lvl = 1'b1;
				if (sts.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req_valid && ready) begin
					unique case (req_type)
						REQ_WRITE: begin
							cmd.wr_level = 1'b1;
							cmd.rsp_load = 1'b1;
							cmd.rsp_sel  = RSP_WRITE;
						end
						REQ_SEARCH: state_d = ST_CLR;
						REQ_QUERY: begin
							cmd.q_capture = 1'b1;
							state_d       = ST_QRY;
						end
						default: begin
							cmd.rsp_load = 1'b1;
							cmd.rsp_sel  = RSP_NONE;
						end
					endcase
				end
			end
			ST_QRY: begin
				cmd.rsp_load = 1'b1;
				cmd.rsp_sel  = RSP_QUERY;
				state_d      = ST_IDLE;
			end
			ST_CLR: begin
				cmd.sweep_dst = 1'b1;
				if (sts.sweep_last) begin
					state_d = ST_SEED;
				end
			end
			ST_SEED: begin
				cmd.seed = 1'b1;
				state_d  = sts.start_in ? ST_POP : ST_DONE;
			end
			ST_POP: begin
				if (sts.queue_empty) begin
					state_d = ST_DONE;
				end else begin
					cmd.pop = 1'b1;
					state_d = ST_CUR;
				end
			end
			ST_CUR: begin
				cmd.cur_load = 1'b1;
				state_d      = ST_EXP;
			end
			ST_EXP: begin
				cmd.exp_load = 1'b1;
				state_d      = sts.cur_done ? ST_POP : ST_NB;
			end
			ST_NB: begin
				if (sts.nb_valid) begin
					cmd.nb_issue = 1'b1;
					state_d      = ST_CHK;
				end else begin
					cmd.nb_next = 1'b1;
					state_d     = sts.k_last ? ST_POP : ST_NB;
				end
			end
			ST_CHK: begin
				cmd.nb_commit = 1'b1;
				cmd.nb_next   = 1'b1;
				state_d       = sts.k_last ? ST_POP : ST_NB;
			end
			ST_DONE: begin
				cmd.rsp_load = 1'b1;
				cmd.rsp_sel  = RSP_SEARCH;
				state_d      = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### rtl/core/bounded_grid_reach_search.sv
// Top level of the bounded grid reach search: controller plus datapath.
// Depends on bgrs_pkg, bgrs_ctrl and bgrs_datapath.
//
//  channel   direction  handshake              payload
//  req       in         req_valid / req_stall  req_t (type, x, y, level)
//  rsp       out        rsp_valid / rsp_stall  rsp_t (status, reach, steps, count)
//  cfg       in         cfg_we                 cfg_index, cfg_data
//
// Write and unused transactions load their result as they are taken; a query first
// reads the distance store, in or out of the grid. A search clears distances over all
// 2^(clog2(MAX_COLS)+clog2(MAX_ROWS)) addresses (4096 by default), then pops and reads
// each reached tile and checks the neighbors of those below the move range.
// After reset the height and distance stores are cleared, with req_stall high.
// A stalled result holds; a new request is taken in the cycle the previous result leaves.
module bounded_grid_reach_search
	import bgrs_pkg::*;
#(
	parameter int MAX_COLS   = DEF_MAX_COLS,
	parameter int MAX_ROWS   = DEF_MAX_ROWS,
	parameter int LEVEL_BITS = DEF_LEVEL_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  req_t                  req,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output rsp_t                  rsp
);

	bgrs_cmd_t cmd;
	bgrs_sts_t sts;

	bgrs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_type  (req.req_type),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	bgrs_datapath #(
		.MAX_COLS   (MAX_COLS),
		.MAX_ROWS   (MAX_ROWS),
		.LEVEL_BITS (LEVEL_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp       (rsp),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps
// Testbench for bounded_grid_reach_search: directed and random transactions.
// Depends on bgrs_pkg and the bounded_grid_reach_search top level.
module tb_top;
	import bgrs_pkg::*;

	localparam int COLS        = DEF_MAX_COLS;
	localparam int ROWS        = DEF_MAX_ROWS;
	localparam int TILES       = COLS * ROWS;
	localparam int CYCLE_LIMIT = 3000000;

	// Expected-response tracker with its own copy of the grid state
	class reach_scoreboard;
		logic [7:0]         height_map[TILES];
		logic [DIST_W-1:0]  step_map[TILES];
		logic [COUNT_W-1:0] found;
		int unsigned        cols_reg, rows_reg, climb_max, drop_max, range_max, org_x, org_y;
		rsp_t               expected_rsp[$];
		int                 errors;

		function new();
			for (int i = 0; i < TILES; i++) begin
				height_map[i] = '0;
				step_map[i]   = UNREACHED;
			end
			found     = '0;
			cols_reg  = 64;
			rows_reg  = 64;
			climb_max = 1;
			drop_max  = 2;
			range_max = 4;
			org_x     = 0;
			org_y     = 0;
			errors    = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				CFG_GRID_WIDTH:  cols_reg  = val & 8'h7F;
				CFG_GRID_HEIGHT: rows_reg  = val & 8'h7F;
				CFG_JUMP_LIMIT:  climb_max = val;
				CFG_FALL_LIMIT:  drop_max  = val;
				CFG_MOVE_RANGE:  range_max = val & 8'h3F;
				CFG_START_X:     org_x     = val & 8'h3F;
				CFG_START_Y:     org_y     = val & 8'h3F;
				default: ;
			endcase
		endfunction

		function bit on_grid(int unsigned x, int unsigned y);
			int unsigned c, r;
			c = (cols_reg > COLS) ? COLS : cols_reg;
			r = (rows_reg > ROWS) ? ROWS : rows_reg;
			return (x < c) && (y < r);
		endfunction

		function bit move_ok(int from, int to);
			int a, b;
			a = height_map[from];
			b = height_map[to];
			if (b > a)
				return (b - a) <= climb_max;
			return (a - b) <= drop_max;
		endfunction

		// Breadth-first flood from the origin tile, bounded by range_max
		function void flood();
			int frontier[$];
			int cur, cx, cy, nx, ny, nb;
			int unsigned d, cnt;
			for (int i = 0; i < TILES; i++)
				step_map[i] = UNREACHED;
			cnt = 0;
			if (on_grid(org_x, org_y)) begin
				cur = org_y * COLS + org_x;
				step_map[cur] = '0;
				frontier = {frontier, cur};
				cnt = 1;
				while (frontier.size() > 0) begin
					cur = frontier.pop_front();
					cx  = cur % COLS;
					cy  = cur / COLS;
					d   = step_map[cur];
					if (d < range_max) begin
						for (int k = 0; k < 4; k++) begin
							nx = cx + ((k == 0) ? 1 : (k == 1) ? -1 : 0);
							ny = cy + ((k == 2) ? 1 : (k == 3) ? -1 : 0);
							if (nx >= 0 && ny >= 0 && on_grid(nx, ny)) begin
								nb = ny * COLS + nx;
								if (step_map[nb] == UNREACHED && move_ok(cur, nb)) begin
									step_map[nb] = DIST_W'(d + 1);
									frontier = {frontier, nb};
									cnt++;
								end
							end
						end
					end
				end
			end
			found = cnt[COUNT_W-1:0];
		endfunction

		// Predict the response of one accepted request
		function void note(req_t r);
			rsp_t e;
			int   t;
			e = '0;
			t = r.tile_y * COLS + r.tile_x;
			case (r.req_type)
				REQ_WRITE: begin
					if (on_grid(r.tile_x, r.tile_y))
						height_map[t] = r.tile_level;
					else
						e.status = 1'b1;
				end
				REQ_SEARCH: begin
					flood();
					e.status = !on_grid(org_x, org_y);
				end
				REQ_QUERY: begin
					if (!on_grid(r.tile_x, r.tile_y))
						e.status = 1'b1;
					else if (step_map[t] != UNREACHED) begin
						e.reachable  = 1'b1;
						e.steps_used = step_map[t][STEPS_W-1:0];
					end
				end
				default: ;
			endcase
			e.reachable_count = found;
			expected_rsp = {expected_rsp, e};
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		task check(rsp_t got);
			rsp_t e;
			if (expected_rsp.size() == 0) begin
				report($sformatf("unexpected response %h", got));
				return;
			end
			e = expected_rsp.pop_front();
			if (got.status !== e.status)
				report($sformatf("status %b, want %b", got.status, e.status));
			if (got.reachable !== e.reachable)
				report($sformatf("reachable %b, want %b", got.reachable, e.reachable));
			if (got.steps_used !== e.steps_used)
				report($sformatf("steps_used %0d, want %0d", got.steps_used, e.steps_used));
			if (got.reachable_count !== e.reachable_count)
				report($sformatf("reachable_count %0d, want %0d",
					got.reachable_count, e.reachable_count));
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  req_valid;
	logic                  req_stall;
	req_t                  req;
	logic                  rsp_valid;
	logic                  rsp_stall;
	rsp_t                  rsp;

	reach_scoreboard sb = new();
	int              send_idle_pct;
	int              recv_idle_pct;
	int              hold_cycles;
	int              cycle_count;

	bounded_grid_reach_search i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Abort on a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Drive the receiver stall: long hold-off first, else random
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			rsp_stall <= 1'b1;
			hold_cycles--;
		end else begin
			rsp_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Check every accepted response
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check(rsp);
	end

	task cfg_write(logic [CFG_IDX_W-1:0] idx, int val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_W'(val);
		@(posedge clk);
		sb.set_reg(idx, CFG_DATA_W'(val));
	endtask

	task cfg_close();
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Offer one transaction, with random gaps in front, and hold until taken
	task send(int kind, int x, int y, int lvl);
		req_t r;
		r.req_type   = 2'(kind);
		r.tile_x     = COORD_W'(x);
		r.tile_y     = COORD_W'(y);
		r.tile_level = LEVEL_IN_W'(lvl);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		do
			@(posedge clk);
		while (req_stall);
		sb.note(r);
	endtask

	// Drop valid and wait for all responses to drain
	task drain();
		@(negedge clk);
		req_valid <= 1'b0;
		while (sb.expected_rsp.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task random_config();
		int w, h;
		w = $urandom_range(1, 12);
		h = $urandom_range(1, 12);
		cfg_write(CFG_GRID_WIDTH, w);
		cfg_write(CFG_GRID_HEIGHT, h);
		cfg_write(CFG_JUMP_LIMIT, ($urandom_range(9) == 0) ? 255 : $urandom_range(4));
		cfg_write(CFG_FALL_LIMIT, ($urandom_range(9) == 0) ? 255 : $urandom_range(4));
		cfg_write(CFG_MOVE_RANGE, ($urandom_range(4) == 0) ? 63 : $urandom_range(8));
		cfg_write(CFG_START_X, ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(w - 1));
		cfg_write(CFG_START_Y, ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(h - 1));
		cfg_close();
	endtask

	// Writes over the grid, one search, then queries; some noise mixed in
	task random_group();
		int lvl;
		for (int i = 0; i < 5; i++) begin
			lvl = $urandom_range(1) ? $urandom_range(255) : $urandom_range(4);
			send(REQ_WRITE, $urandom_range(11), $urandom_range(11), lvl);
		end
		send(REQ_SEARCH, $urandom_range(63), $urandom_range(63), $urandom_range(255));
		for (int i = 0; i < 4; i++)
			send(REQ_QUERY, $urandom_range(11), $urandom_range(11), $urandom_range(255));
		if ($urandom_range(2) == 0)
			send($urandom_range(3), $urandom_range(63), $urandom_range(63), $urandom_range(255));
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		req_valid     = 1'b0;
		req           = '0;
		rsp_stall     = 1'b0;
		send_idle_pct = 15;
		recv_idle_pct = 83;
		hold_cycles   = 0;
		cycle_count   = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: default grid, climb and drop edges, far corner, unused type
		send(REQ_WRITE, 1, 0, 1);
		send(REQ_WRITE, 0, 1, 3);
		send(REQ_WRITE, 63, 63, 255);
		send(REQ_SEARCH, 0, 0, 0);
		send(REQ_QUERY, 0, 0, 0);
		send(REQ_QUERY, 1, 0, 0);
		send(REQ_QUERY, 0, 1, 0);
		send(REQ_QUERY, 63, 63, 0);
		send(3, 63, 63, 255);
		drain();

		// Zero-size grid: everything lies outside
		cfg_write(CFG_GRID_WIDTH, 0);
		cfg_close();
		send(REQ_WRITE, 0, 0, 7);
		send(REQ_QUERY, 0, 0, 0);
		send(REQ_SEARCH, 0, 0, 0);
		drain();

		// Oversized grid, loose climb, no drop, full range, start at far corner
		cfg_write(CFG_GRID_WIDTH, 255);
		cfg_write(CFG_GRID_HEIGHT, 255);
		cfg_write(CFG_JUMP_LIMIT, 255);
		cfg_write(CFG_FALL_LIMIT, 0);
		cfg_write(CFG_MOVE_RANGE, 63);
		cfg_write(CFG_START_X, 63);
		cfg_write(CFG_START_Y, 63);
		cfg_close();
		send(REQ_SEARCH, 0, 0, 0);
		send(REQ_QUERY, 62, 63, 0);
		send(REQ_QUERY, 0, 0, 0);
		drain();

		// Zero range; then start outside a narrow grid, query after resize
		cfg_write(CFG_MOVE_RANGE, 0);
		cfg_write(CFG_START_X, 0);
		cfg_write(CFG_START_Y, 0);
		cfg_close();
		send(REQ_SEARCH, 0, 0, 0);
		send(REQ_QUERY, 1, 0, 0);
		drain();
		cfg_write(CFG_GRID_WIDTH, 5);
		cfg_write(CFG_START_X, 10);
		cfg_close();
		send(REQ_QUERY, 0, 0, 0);
		send(REQ_QUERY, 6, 0, 0);
		send(REQ_SEARCH, 0, 0, 0);
		drain();

		// Random phases with changing idle patterns
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 83 : 0;
			recv_idle_pct = (phase == 0) ? 83 : (phase == 1) ? 15 : 0;
			for (int g = 0; g < 3; g++) begin
				random_config();
				// Hold the receiver off while the sender keeps offering
				if (phase == 2 && g == 0)
					hold_cycles = 400;
				random_group();
				drain();
			end
		end

		repeat (50) @(posedge clk);
		if (sb.errors == 0 && sb.expected_rsp.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule
